/* src/mact_pkg.sv */
`default_nettype none
package mact_pkg;

   localparam int AXIS_BITS      = 12;
   localparam int SAMPLE_BITS    = 24;
   localparam int COS_TABLE_BITS = 10;
   localparam int NUM_AXES       = 5;

   localparam int REG_BITS       = 60;
   localparam int CSR_INDEX_BITS = 8;
   localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int AXIS_IDX_BITS  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int DIV_CNT_BITS   = $clog2(COS_TABLE_BITS);
   localparam int TAB_SIZE       = 1 << COS_TABLE_BITS;
   localparam int W_BITS         = 31;
   localparam int SDW            = AXIS_BITS + 2;

   localparam logic [W_BITS-1:0] ONE_Q30 = 31'h4000_0000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [REG_BITS-1:0] AXIS_LEN_RESET = 60'd281543712968705;
   localparam logic [REG_BITS-1:0] TAPER_RESET    = 60'd20480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AXIS_LENGTHS  = 8'd0,
      CSR_TAPER_LENGTHS = 8'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_LOOKUP,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic div_step;
      logic lookup;
      logic mul;
      logic next_axis;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic unity;
      logic last_axis;
      logic div_last;
      logic out_free;
   } dp_sts_type;

   typedef logic [W_BITS-1:0] cos_tab_type [TAB_SIZE];

   // Shift-and-subtract quotient; only evaluated while the cosine table is built
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave cosine in Q30 by an eleven-term Taylor series, each term truncated
   function automatic logic [W_BITS-1:0] cos_q30(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned den;
      x    = (longint'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = 64'(ONE_Q30);
      sum  = longint'(ONE_Q30);
      for (int n = 1; n <= 10; n++) begin
         den  = longint'((2 * n - 1) * (2 * n));
         term = (term * x2) >> 30;
         term = udiv64(term, den);
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return W_BITS'(sum);
   endfunction

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type t;
      for (int k = 0; k < TAB_SIZE; k++) begin
         t[k] = cos_q30(k);
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

endpackage
`default_nettype wire

/* src/mact_ctrl.sv */
`default_nettype none
module mact_ctrl
   import mact_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (!sts.unity) begin
               state_in = ST_DIV;
            end else if (sts.last_axis) begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = sts.last_axis ? ST_FINISH : ST_SETUP;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SETUP: begin
            cmd.setup     = 1'b1;
            // skip the divide and multiply where the weight is one
            cmd.next_axis = sts.unity;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_MUL: begin
            cmd.mul       = 1'b1;
            cmd.next_axis = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/mact_dp.sv */
`default_nettype none
module mact_dp
   import mact_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [SAMPLE_BITS-1:0]     sample,
   input  wire                        csr_valid,
   input  wire  [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [REG_BITS-1:0]        csr_data,
   input  wire                        rsp_tready,
   output logic                       rsp_tvalid,
   output logic [SAMPLE_BITS-1:0]     rsp_sample,
   output logic                       rsp_last,
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts
);

   logic [REG_BITS-1:0]      axis_len_ff;
   logic [REG_BITS-1:0]      taper_len_ff;
   logic [AXIS_BITS-1:0]     pos_ff [NUM_AXES];
   logic [AXIS_BITS-1:0]     pos_in [NUM_AXES];
   logic [AXIS_IDX_BITS-1:0] axis_ff;
   logic [AXIS_IDX_BITS-1:0] axis_in;

   logic signed [SAMPLE_BITS-1:0] acc_ff;
   logic [AXIS_BITS-1:0]          rem_ff;
   logic [AXIS_BITS-1:0]          divisor_ff;
   logic [COS_TABLE_BITS-1:0]     quo_ff;
   logic [DIV_CNT_BITS-1:0]       cnt_ff;
   logic                          invert_ff;
   logic [W_BITS-1:0]             cos_ff;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_last_ff;

   // per-axis rule evaluation
   logic [AXIS_BITS-1:0] pos_sel;
   logic [AXIS_BITS-1:0] len_raw;
   logic [AXIS_BITS-1:0] taper_sel;
   logic signed [SDW-1:0] i_s;
   logic signed [SDW-1:0] n_s;
   logic signed [SDW-1:0] l_s;
   logic signed [SDW-1:0] nml_s;
   logic signed [SDW-1:0] d_s;
   logic rule_a;
   logic rule_b;
   logic rule_c;
   logic unity;

   always_comb begin
      pos_sel   = pos_ff[axis_ff];
      len_raw   = axis_len_ff[32'(axis_ff) * AXIS_BITS +: AXIS_BITS];
      taper_sel = taper_len_ff[32'(axis_ff) * AXIS_BITS +: AXIS_BITS];
      i_s   = $signed({2'b00, pos_sel});
      n_s   = (len_raw == '0) ? SDW'(1) : $signed({2'b00, len_raw});
      l_s   = $signed({2'b00, taper_sel});
      nml_s = n_s - l_s;
      rule_a = (taper_sel != '0) && (i_s < l_s);
      rule_b = (i_s >= l_s) && (i_s <= nml_s);
      rule_c = (taper_sel != '0) && (i_s > nml_s) && (i_s < n_s);
      unity  = !rule_c && (rule_b || !rule_a);
      // fall-off taper measures from n-l, rise taper from zero
      d_s    = rule_c ? (i_s - nml_s) : i_s;
   end

   // one restoring-divide step: remainder stays below the divisor
   logic [AXIS_BITS:0]   rem_dbl;
   logic                 rem_ge;
   logic [AXIS_BITS-1:0] rem_next;
   always_comb begin
      rem_dbl  = {rem_ff, 1'b0};
      rem_ge   = rem_dbl >= {1'b0, divisor_ff};
      rem_next = rem_ge ? AXIS_BITS'(rem_dbl - {1'b0, divisor_ff}) : rem_dbl[AXIS_BITS-1:0];
   end

   logic [W_BITS-1:0] weight;
   always_comb begin
      weight = invert_ff ? ONE_Q30 - cos_ff : cos_ff;
   end

   logic signed [SAMPLE_BITS+W_BITS:0] prod;
   always_comb begin
      prod = acc_ff * $signed({1'b0, weight});
   end

   // position carry chain, axis 0 first
   logic [AXIS_BITS-1:0] len_eff [NUM_AXES];
   logic                 last_pos [NUM_AXES];
   logic                 carry;
   always_comb begin
      carry = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         len_eff[a]  = (axis_len_ff[a*AXIS_BITS +: AXIS_BITS] == '0) ? AXIS_BITS'(1)
                       : axis_len_ff[a*AXIS_BITS +: AXIS_BITS];
         last_pos[a] = ({1'b0, pos_ff[a]} + 1'b1) >= {1'b0, len_eff[a]};
         pos_in[a]   = pos_ff[a];
         if (carry) begin
            pos_in[a] = last_pos[a] ? '0 : pos_ff[a] + 1'b1;
         end
         carry = carry & last_pos[a];
      end
   end

   always_comb begin
      axis_in = axis_ff;
      if (cmd.load) begin
         axis_in = '0;
      end else if (cmd.next_axis) begin
         axis_in = sts.last_axis ? '0 : axis_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_len_ff  <= AXIS_LEN_RESET;
         taper_len_ff <= TAPER_RESET;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            pos_ff[a] <= '0;
         end
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_AXIS_LENGTHS) axis_len_ff <= csr_data;
            if (csr_index == CSR_TAPER_LENGTHS) taper_len_ff <= csr_data;
         end
         axis_ff <= axis_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
               pos_ff[a] <= pos_in[a];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= $signed(sample);
      end else if (cmd.mul) begin
         acc_ff <= prod[30 +: SAMPLE_BITS];
      end
      if (cmd.setup) begin
         rem_ff     <= AXIS_BITS'(d_s);
         divisor_ff <= taper_sel;
         quo_ff     <= '0;
         cnt_ff     <= DIV_CNT_BITS'(COS_TABLE_BITS - 1);
         invert_ff  <= !rule_c;
      end else if (cmd.div_step) begin
         rem_ff <= rem_next;
         quo_ff <= {quo_ff[COS_TABLE_BITS-2:0], rem_ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.lookup) begin
         cos_ff <= COS_TAB[quo_ff];
      end
      if (cmd.finish) begin
         rsp_sample_ff <= acc_ff;
         rsp_last_ff   <= carry;
      end
   end

   always_comb begin
      sts.unity     = unity;
      sts.last_axis = (axis_ff == AXIS_IDX_BITS'(NUM_AXES - 1));
      sts.div_last  = (cnt_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

/* src/multi_axis_cosine_taper.sv */
`default_nettype none
// Each accepted beat visits every axis in a setup step; an axis whose weight is not one
// also takes a 10-step phase divide, a table read and a multiply, and the result is then
// registered for output. The shared divider and multiplier work through the axes in turn,
// so no new beat is taken until the last one's result is registered. A waiting result
// holds the next beat at its last step.
// Reset clears positions, output valid and the controller; registers take their defaults.
module multi_axis_cosine_taper
   import mact_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [TDATA_BITS-1:0]      req_tdata,   // [23:0] sample
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [TDATA_BITS-1:0]      rsp_tdata,   // [23:0] tapered_sample
   output logic                       rsp_tlast,   // volume_end
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [REG_BITS-1:0]        csr_data
);

   dp_cmd_type             cmd;
   dp_sts_type             sts;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   mact_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mact_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign rsp_tdata = TDATA_BITS'(rsp_sample);
   assign csr_ready = 1'b1;

endmodule
`default_nettype wire

/* src/mact_check.sv */
`default_nettype none
module mact_check
   import mact_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [TDATA_BITS-1:0]  rsp_tdata,
   input wire                   rsp_tlast
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after a beat");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while input side was idle");

endmodule

bind multi_axis_cosine_taper mact_check u_mact_check (.*);
`default_nettype wire
